// ----- hw/rtl/dcdb_pkg.sv -----
// ----------------------------------------------------------------------------
// dcdb_pkg
// Shared constants, permutation tables and item types for the dihedral
// check-symbol block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcdb_pkg;

    localparam int ALPHABET_SIZE = 58;
    localparam int HALF_SIZE     = ALPHABET_SIZE / 2;
    localparam int GROUP_ORDER   = 2 * HALF_SIZE;
    localparam int POS_CYCLE     = 12;
    localparam int SYM_W         = 6;
    localparam int POS_W         = 4;
    localparam int TBL_ROWS      = 4;
    localparam int TBL_COLS      = 1 << SYM_W;
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = 2;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(POS_CYCLE - 1);
    localparam logic [POS_W:0]   POS_WRAP = (POS_W + 1)'(POS_CYCLE);

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic int perm_once_f(int b);
        int r;
        if (b == 0) begin
            r = 0;
        end else if (b < HALF_SIZE) begin
            r = GROUP_ORDER - b;
        end else begin
            r = b - HALF_SIZE + 1;
        end
        return r;
    endfunction

    // rows 0..3: reduce the raw symbol and apply the permutation row times
    function automatic logic [TBL_ROWS*TBL_COLS*SYM_W-1:0] build_lo_tbl();
        logic [TBL_ROWS*TBL_COLS*SYM_W-1:0] t;
        int b;
        t = '0;
        for (int r = 0; r < TBL_ROWS; r++) begin
            for (int s = 0; s < TBL_COLS; s++) begin
                b = s % GROUP_ORDER;
                for (int k = 0; k < r; k++) begin
                    b = perm_once_f(b);
                end
                t[(r*TBL_COLS+s)*SYM_W +: SYM_W] = SYM_W'(b);
            end
        end
        return t;
    endfunction

    // rows 0..2: apply the permutation 4*row times, row 3 unused
    function automatic logic [TBL_ROWS*TBL_COLS*SYM_W-1:0] build_hi_tbl();
        logic [TBL_ROWS*TBL_COLS*SYM_W-1:0] t;
        int b;
        int n;
        t = '0;
        for (int r = 0; r < TBL_ROWS; r++) begin
            n = (r < 3) ? 4 * r : 0;
            for (int s = 0; s < TBL_COLS; s++) begin
                b = s % GROUP_ORDER;
                for (int k = 0; k < n; k++) begin
                    b = perm_once_f(b);
                end
                t[(r*TBL_COLS+s)*SYM_W +: SYM_W] = SYM_W'(b);
            end
        end
        return t;
    endfunction

    localparam logic [TBL_ROWS*TBL_COLS*SYM_W-1:0] PERM_LO_TBL = build_lo_tbl();
    localparam logic [TBL_ROWS*TBL_COLS*SYM_W-1:0] PERM_HI_TBL = build_hi_tbl();

endpackage

`default_nettype wire

// ----- hw/rtl/dcdb_front.sv -----
// ----------------------------------------------------------------------------
// dcdb_front
// Accepts symbols, tracks position and applies the position permutation in
// two registered table stages before handing items to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dcdb_front
    import dcdb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_wr_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [SYM_W-1:0] i_symbol,
    input  wire logic             i_last,
    output logic                  o_push,
    output t_item                 o_push_item,
    input  wire t_q_stat          i_q_stat
);

    logic             r_mode;
    logic [POS_W-1:0] r_pos;
    logic             r_v1;
    logic [SYM_W-1:0] r_s1_sym;
    logic [1:0]       r_s1_hi;
    logic             r_s1_last;
    logic             r_v2;
    t_item            r_s2;

    logic             move2;
    logic             load2;
    logic             adv1;
    logic             accept;
    logic [POS_W:0]   row_sum;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] n_pos;
    logic [SYM_W-1:0] lo_sym;
    logic [SYM_W-1:0] hi_sym;

    assign move2      = r_v2 && !i_q_stat.full;
    assign load2      = !r_v2 || move2;
    assign adv1       = r_v1 && load2;
    assign o_in_stall = r_v1 && !load2;
    assign accept     = i_in_valid && !o_in_stall;

    assign o_push      = move2;
    assign o_push_item = r_s2;

    always_comb begin
        row_sum = {1'b0, r_pos} + {{POS_W{1'b0}}, r_mode};
        if (row_sum >= POS_WRAP) begin
            row_sum = row_sum - POS_WRAP;
        end
        row = row_sum[POS_W-1:0];
        if (i_last || r_pos == POS_LAST) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
        lo_sym = PERM_LO_TBL[{row[1:0], i_symbol}*SYM_W +: SYM_W];
        hi_sym = PERM_HI_TBL[{r_s1_hi, r_s1_sym}*SYM_W +: SYM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_pos  <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (accept) begin
                r_pos <= n_pos;
                r_v1  <= 1'b1;
            end else if (adv1) begin
                r_v1  <= 1'b0;
            end
            if (adv1) begin
                r_v2 <= 1'b1;
            end else if (move2) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sym  <= lo_sym;
            r_s1_hi   <= row[3:2];
            r_s1_last <= i_last;
        end
        if (adv1) begin
            r_s2.sym  <= hi_sym;
            r_s2.last <= r_s1_last;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dcdb_queue.sv -----
// ----------------------------------------------------------------------------
// dcdb_queue
// Short first-in first-out queue of permuted items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dcdb_queue
    import dcdb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_push_item,
    input  wire logic  i_pop,
    output t_item      o_head,
    output t_q_stat    o_stat
);

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dcdb_back.sv -----
// ----------------------------------------------------------------------------
// dcdb_back
// Multiplies queued items into the dihedral accumulator and registers the
// check symbol and valid flag on the last symbol of a string.
// ----------------------------------------------------------------------------
`default_nettype none

module dcdb_back
    import dcdb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_item    i_head,
    input  wire t_q_stat  i_q_stat,
    output logic          o_pop,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output logic [SYM_W-1:0] o_check_symbol,
    output logic          o_valid_res
);

    localparam logic [SYM_W:0] HALF  = (SYM_W + 1)'(HALF_SIZE);
    localparam logic [SYM_W:0] GROUP = (SYM_W + 1)'(GROUP_ORDER);

    function automatic logic [SYM_W:0] reflect(logic [SYM_W:0] b);
        logic [SYM_W:0] r;
        if (b == '0) begin
            r = HALF;
        end else if (b == HALF) begin
            r = '0;
        end else begin
            r = GROUP - b;
        end
        return r;
    endfunction

    function automatic logic [SYM_W-1:0] grp_mul(logic [SYM_W-1:0] a, logic [SYM_W-1:0] b);
        logic [SYM_W:0] steps;
        logic [SYM_W:0] bb;
        logic [SYM_W:0] base;
        logic [SYM_W:0] s;
        steps = {1'b0, a};
        bb    = {1'b0, b};
        base  = '0;
        if (steps >= HALF) begin
            steps = steps - HALF;
            bb    = reflect(bb);
        end
        if (bb >= HALF) begin
            base = HALF;
            bb   = bb - HALF;
        end
        s = bb + steps;
        if (s >= HALF) begin
            s = s - HALF;
        end
        return SYM_W'(base + s);
    endfunction

    logic [SYM_W-1:0] r_acc;
    logic             r_out_valid;
    logic [SYM_W-1:0] r_chk;
    logic             r_ok;

    logic             out_free;
    logic [SYM_W-1:0] prod;
    logic [SYM_W:0]   prod_w;
    logic [SYM_W-1:0] inv;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = !i_q_stat.empty && (!i_head.last || out_free);
    assign prod     = grp_mul(r_acc, i_head.sym);
    assign prod_w   = {1'b0, prod};

    always_comb begin
        if (prod_w >= HALF || prod == '0) begin
            inv = prod;
        end else begin
            inv = SYM_W'(HALF - prod_w);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_check_symbol = r_chk;
    assign o_valid_res    = r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_acc <= i_head.last ? '0 : prod;
            end
            if (o_pop && i_head.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_chk <= inv;
            r_ok  <= (prod == '0);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dihedral_check_digit_base58.sv -----
// throughput: one symbol per cycle while the input is not stalled; the
//   four-entry queue absorbs output stalls
// reset: synchronous active-low; clears accumulator, position, mode, queue
//   and output valid
// ----------------------------------------------------------------------------
// dihedral_check_digit_base58
// Dihedral-group check symbol over a 58-symbol alphabet, top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dihedral_check_digit_base58
    import dcdb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_wr_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [SYM_W-1:0] i_symbol,
    input  wire logic             i_last,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [SYM_W-1:0]      o_check_symbol,
    output logic                  o_valid_res
);

    logic    push;
    t_item   push_item;
    logic    pop;
    t_item   head;
    t_q_stat q_stat;

    dcdb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_symbol      (i_symbol),
        .i_last        (i_last),
        .o_push        (push),
        .o_push_item   (push_item),
        .i_q_stat      (q_stat)
    );

    dcdb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    dcdb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_check_symbol (o_check_symbol),
        .o_valid_res    (o_valid_res)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/dcdb_checker.sv -----
// ----------------------------------------------------------------------------
// dcdb_checker
// Port-level checks on the result channel of the check-symbol block.
// ----------------------------------------------------------------------------
`default_nettype none

module dcdb_checker
    import dcdb_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire logic [SYM_W-1:0] o_check_symbol,
    input wire logic             o_valid_res
);

    localparam logic [SYM_W:0] GROUP = (SYM_W + 1)'(GROUP_ORDER);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_check_symbol) && $stable(o_valid_res))
        else $error("result changed while stalled");

    a_ok_iff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_valid_res == (o_check_symbol == '0)))
        else $error("valid flag disagrees with check symbol");

    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_check_symbol} < GROUP))
        else $error("check symbol out of range");

endmodule

bind dihedral_check_digit_base58 dcdb_checker u_dcdb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_check_symbol (o_check_symbol),
    .o_valid_res    (o_valid_res)
);

`default_nettype wire

// ----- sim/dcdb_check_monitor.sv -----
// ----------------------------------------------------------------------------
// dcdb_check_monitor
// Watches the symbol, result and mode ports of the dihedral check-symbol
// block. It keeps its own dihedral product and position count, queues the
// check symbol and valid flag that each final symbol should produce, and
// compares every accepted result with the oldest one queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcdb_check_monitor
    import dcdb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_wr_data,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_stall,
    input  wire logic [SYM_W-1:0] i_symbol,
    input  wire logic             i_last,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_stall,
    input  wire logic [SYM_W-1:0] i_check_symbol,
    input  wire logic             i_valid_res,
    output int                    o_mismatches,
    output int                    o_pending
);

    typedef struct packed {
        logic [SYM_W-1:0] check_symbol;
        logic             valid_res;
    } t_check_result;

    logic             gen_mode;
    logic [SYM_W-1:0] product;
    logic [POS_W-1:0] position;
    t_check_result    expected_checks[$];
    int               mismatch_count;

    // permute by position row, multiply into the product, emit on the final symbol
    task automatic fold_symbol(input logic [SYM_W-1:0] sym, input logic last_sym);
        int            b;
        int            a;
        int            steps;
        int            half_base;
        int            row;
        int            inv;
        int            k;
        t_check_result res;
        b = int'(sym) % GROUP_ORDER;
        row = (int'(position) + int'(gen_mode)) % POS_CYCLE;
        for (k = 0; k < row; k++) begin
            if (b == 0) begin
                b = 0;
            end else if (b < HALF_SIZE) begin
                b = GROUP_ORDER - b;
            end else begin
                b = b - HALF_SIZE + 1;
            end
        end
        a = int'(product) % GROUP_ORDER;
        steps = a;
        if (a >= HALF_SIZE) begin
            steps = a - HALF_SIZE;
            if (b < HALF_SIZE) begin
                b = (b == 0) ? HALF_SIZE : GROUP_ORDER - b;
            end else begin
                b = (b == HALF_SIZE) ? 0 : GROUP_ORDER - b;
            end
        end
        half_base = 0;
        if (b >= HALF_SIZE) begin
            half_base = HALF_SIZE;
            b -= HALF_SIZE;
        end
        a = half_base + (b + steps) % HALF_SIZE;
        product = SYM_W'(a);
        position = POS_W'((int'(position) + 1) % POS_CYCLE);
        if (last_sym) begin
            if (a >= HALF_SIZE) begin
                inv = a;
            end else if (a != 0) begin
                inv = HALF_SIZE - a;
            end else begin
                inv = 0;
            end
            res.check_symbol = SYM_W'(inv);
            res.valid_res = (a == 0);
            expected_checks.push_back(res);
            product = '0;
            position = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_check_result want;
        if (!i_rst_n) begin
            gen_mode = 1'b0;
            product = '0;
            position = '0;
            expected_checks.delete();
            mismatch_count = 0;
        end else begin
            if (i_cfg_wr_en) begin
                gen_mode = i_cfg_wr_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_checks.size() == 0) begin
                    $error("unexpected result: check_symbol %0d valid_res %0d",
                           i_check_symbol, i_valid_res);
                    mismatch_count++;
                end else begin
                    want = expected_checks.pop_front();
                    if (i_check_symbol !== want.check_symbol) begin
                        $error("check_symbol: expected %0d, got %0d",
                               want.check_symbol, i_check_symbol);
                        mismatch_count++;
                    end
                    if (i_valid_res !== want.valid_res) begin
                        $error("valid_res: expected %0d, got %0d",
                               want.valid_res, i_valid_res);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fold_symbol(i_symbol, i_last);
            end
        end
        o_mismatches <= mismatch_count;
        o_pending <= expected_checks.size();
    end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the dihedral check-symbol block with short directed strings, then
// rounds that generate check symbols and validate the same strings with the
// check symbol prepended (some corrupted), then a stretch of random symbols.
// Both sides idle at random; the monitor module does all the checking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import dcdb_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int ROUNDS      = 4;
    localparam int GEN_STRINGS = 10;
    localparam int NOISE_ITEMS = 120;
    localparam int SETTLE      = 8;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic             cfg_wr_data = 1'b0;
    logic             in_valid = 1'b0;
    logic [SYM_W-1:0] symbol = '0;
    logic             sym_last = 1'b0;
    logic             out_stall = 1'b1;
    logic             in_stall;
    logic             out_valid;
    logic [SYM_W-1:0] check_symbol;
    logic             valid_res;

    int               mismatches;
    int               pending;
    int               stuck_cycles = 0;
    int               in_calm = 0;
    int               out_calm = 0;

    logic [SYM_W-1:0] word[$];
    logic [SYM_W-1:0] gen_checks[$];
    logic [SYM_W-1:0] payload_syms[$];
    int               payload_lens[$];

    always #5 clk = ~clk;

    dihedral_check_digit_base58 u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_symbol       (symbol),
        .i_last         (sym_last),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_check_symbol (check_symbol),
        .o_valid_res    (valid_res)
    );

    dcdb_check_monitor u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_symbol       (symbol),
        .i_last         (sym_last),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_check_symbol (check_symbol),
        .i_valid_res    (valid_res),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // idle cycles before the next item, with stretches of none
    task automatic draw_gap(inout int calm, output int gap);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 24) == 0) begin
                calm = $urandom_range(8, 40);
            end
            gap = $urandom_range(0, 16);
        end
    endtask

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last_sym);
        int gap;
        draw_gap(in_calm, gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            symbol <= SYM_W'($urandom);
            sym_last <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        symbol <= sym;
        sym_last <= last_sym;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_word();
        int i;
        for (i = 0; i < word.size(); i++) begin
            send_symbol(word[i], i == word.size() - 1);
        end
    endtask

    // mode changes only once every result is out and the pipeline has drained
    task automatic set_mode(input logic mode);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // result side stall
    initial begin
        int gap;
        do @(posedge clk); while (!rst_n);
        forever begin
            draw_gap(out_calm, gap);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            gen_checks.push_back(check_symbol);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STUCK_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        int len;
        int k;
        int base;
        int r;
        int s;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone symbols: identity, rotations, reflections, out of range
        set_mode(1'b0);
        word = '{6'd0, 6'd57, 6'd28, 6'd29, 6'd1, 6'd63, 6'd58};
        for (k = 0; k < 7; k++) begin
            send_symbol(word[k], 1'b1);
        end
        // longer than one position cycle
        word = '{6'd57, 6'd0, 6'd1, 6'd28, 6'd29, 6'd30, 6'd63,
                 6'd58, 6'd42, 6'd13, 6'd56, 6'd2, 6'd31, 6'd17};
        send_word();
        set_mode(1'b1);
        word = '{6'd5, 6'd44, 6'd60};
        send_word();

        for (r = 0; r < ROUNDS; r++) begin
            set_mode(1'b1);
            gen_checks.delete();
            payload_syms.delete();
            payload_lens.delete();
            for (s = 0; s < GEN_STRINGS; s++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(1, 12);
                word.delete();
                repeat (len) begin
                    word.push_back(($urandom_range(0, 15) == 0)
                                   ? SYM_W'($urandom_range(58, 63))
                                   : SYM_W'($urandom_range(0, 57)));
                end
                payload_lens.push_back(len);
                for (k = 0; k < len; k++) begin
                    payload_syms.push_back(word[k]);
                end
                send_word();
            end

            // validate each string with its check symbol in the first place
            set_mode(1'b0);
            base = 0;
            for (s = 0; s < GEN_STRINGS; s++) begin
                word.delete();
                word.push_back((s < gen_checks.size()) ? gen_checks[s] : '0);
                for (k = 0; k < payload_lens[s]; k++) begin
                    word.push_back(payload_syms[base + k]);
                end
                base += payload_lens[s];
                if ($urandom_range(0, 3) == 0) begin
                    word[$urandom_range(0, word.size() - 1)] = SYM_W'($urandom_range(0, 63));
                end
                send_word();
            end
        end

        set_mode(1'($urandom_range(0, 1)));
        for (k = 0; k < NOISE_ITEMS; k++) begin
            send_symbol(SYM_W'($urandom_range(0, 63)), $urandom_range(0, 5) == 0);
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
